[sv/lht_pkg.sv]
// Label hash table: shared payload types and fixed codes.
// No dependencies; imported by lht_hash, label_hash_table, lht_checker and the testbench.
package lht_pkg;

    // Operation codes
    localparam logic [1:0] OP_INSERT     = 2'd0;
    localparam logic [1:0] OP_INSERT_ABS = 2'd1;
    localparam logic [1:0] OP_LOOKUP     = 2'd2;
    localparam logic [1:0] OP_RESERVED   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Hash constants
    localparam logic [31:0] HASH_MUL   = 32'd65521;
    localparam logic [31:0] HASH_ADD   = 32'd31;
    localparam int          HASH_SHIFT = 16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [30:0] label_id;
        logic [31:0] offset;
        logic [7:0]  section;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] entry_index;
    } rsp_t;

endpackage

[sv/lht_hash.sv]
// Label hash table: two-stage bucket hash, one multiply per stage.
// Depends on lht_pkg for the hash constants.
module lht_hash
    import lht_pkg::*;
#(
    parameter int BKT_W = 10
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [30:0]      label_id,
    output logic             hash_valid,
    output logic [BKT_W-1:0] bucket
);

    logic        v1_reg;
    logic        v2_reg;
    logic [31:0] h1_reg;
    logic [31:0] h2_reg;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
    end

    // First and second rounds, 32-bit wrap
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            h1_reg <= {1'b0, label_id} * HASH_MUL + HASH_ADD;
        end
        if (v1_reg)
        begin
            h2_reg <= h1_reg * HASH_MUL + HASH_ADD;
        end
    end

    assign hash_valid = v2_reg;
    assign bucket     = h2_reg[HASH_SHIFT +: BKT_W];

endmodule

[sv/lht_head_mem.sv]
// Label hash table: bucket head memory, one write and one read port.
// Read data is registered. No package dependency.
module lht_head_mem #(
    parameter int BUCKETS = 1024,
    parameter int BKT_W   = 10,
    parameter int IDX_W   = 12
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [BKT_W-1:0] waddr,
    input  logic [IDX_W-1:0] wdata,
    input  logic             re,
    input  logic [BKT_W-1:0] raddr,
    output logic [IDX_W-1:0] rdata
);

    logic [IDX_W-1:0] mem [BUCKETS];
    logic [IDX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/lht_entry_mem.sv]
// Label hash table: entry memory holding id, offset, section and chain link.
// Read data is registered. No package dependency.
module lht_entry_mem #(
    parameter int ENTRIES = 4096,
    parameter int IDX_W   = 12
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  logic [30:0]      wr_id,
    input  logic [31:0]      wr_offset,
    input  logic [7:0]       wr_section,
    input  logic [IDX_W-1:0] wr_link,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output logic [30:0]      rd_id,
    output logic [IDX_W-1:0] rd_link
);

    typedef struct packed {
        logic [30:0]      id;
        logic [31:0]      offset;
        logic [7:0]       section;
        logic [IDX_W-1:0] link;
    } entry_t;

    entry_t mem [ENTRIES];
    entry_t rd_reg;
    entry_t wr_word;

    assign wr_word = '{id: wr_id, offset: wr_offset, section: wr_section, link: wr_link};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wr_word;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    assign rd_id   = rd_reg.id;
    assign rd_link = rd_reg.link;

endmodule

[sv/label_hash_table.sv]
// Label hash table top level: control sequencer, result register, config.
// Depends on lht_pkg, lht_hash, lht_head_mem and lht_entry_mem.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: operation,
//   label_id, offset, section. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns one item per request: status and entry_index.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes abs_section_code;
//   cfg_ready is always high, write only while the block is idle.
// Steps from accept to rsp_valid:
//   ignored id, reserved operation or full table: answered from S_IDLE.
//   insert: two hash stages, head read issue and return, push.
//   lookup: hash and head read as for insert, then one read per chain entry.
// One item is in work at a time; req_ready is high only while idle, and
// the next item can be taken while the last result still waits on rsp.
// Reset: a clearing pass writes every bucket head to empty, with
//   req_ready low; cfg writes are taken meanwhile.
// Stall: a finished result parks in a holding register until rsp frees,
//   and no new item is taken until then.
module label_hash_table
    import lht_pkg::*;
#(
    parameter int ENTRIES = 4096,
    parameter int BUCKETS = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int FILL_W = IDX_W + 1;
    localparam logic [BKT_W-1:0]  CLR_LAST  = BKT_W'(BUCKETS - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(ENTRIES);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_HREAD = 7'b0001000,
        S_HEAD  = 7'b0010000,
        S_CHASE = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [BKT_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [7:0]        abs_sec_reg;
    req_t              req_reg;
    rsp_t              rsp_reg, rsp_next;
    rsp_t              res_reg, res_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              accept;
    logic              is_insert;
    logic              out_free;
    logic [IDX_W-1:0]  slot;
    logic              fin;
    rsp_t              fin_rsp;

    logic              hash_start;
    logic              hash_valid;
    logic [BKT_W-1:0]  bucket;

    logic              hd_we, hd_re;
    logic [BKT_W-1:0]  hd_waddr;
    logic [IDX_W-1:0]  hd_wdata, hd_rdata;

    logic              en_we, en_re;
    logic [IDX_W-1:0]  en_raddr;
    logic [7:0]        en_section;
    logic [30:0]       rd_id;
    logic [IDX_W-1:0]  rd_link;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign is_insert = (req_reg.operation == OP_INSERT) || (req_reg.operation == OP_INSERT_ABS);
    assign slot      = fill_reg[IDX_W-1:0];
    assign en_section = (req_reg.operation == OP_INSERT) ? req_reg.section : abs_sec_reg;

    lht_hash #(.BKT_W(BKT_W)) u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (hash_start),
        .label_id   (req.label_id),
        .hash_valid (hash_valid),
        .bucket     (bucket)
    );

    lht_head_mem #(.BUCKETS(BUCKETS), .BKT_W(BKT_W), .IDX_W(IDX_W)) u_head (
        .clk   (clk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .re    (hd_re),
        .raddr (bucket),
        .rdata (hd_rdata)
    );

    lht_entry_mem #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_entry (
        .clk        (clk),
        .we         (en_we),
        .waddr      (slot),
        .wr_id      (req_reg.label_id),
        .wr_offset  (req_reg.offset),
        .wr_section (en_section),
        .wr_link    (hd_rdata),
        .re         (en_re),
        .raddr      (en_raddr),
        .rd_id      (rd_id),
        .rd_link    (rd_link)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        clr_next       = clr_reg;
        cur_next       = cur_reg;
        fin            = 1'b0;
        fin_rsp        = '{status: ST_DONE, entry_index: 12'd0};
        hash_start     = 1'b0;
        hd_we          = 1'b0;
        hd_re          = 1'b0;
        hd_waddr       = bucket;
        hd_wdata       = slot;
        en_we          = 1'b0;
        en_re          = 1'b0;
        en_raddr       = cur_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                hd_we    = 1'b1;
                hd_waddr = clr_reg;
                hd_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    priority if (req.label_id == 31'd0 || req.operation == OP_RESERVED)
                    begin
                        fin     = 1'b1;
                        fin_rsp = '{status: ST_IGNORED, entry_index: 12'd0};
                    end
                    else if (req.operation != OP_LOOKUP && fill_reg >= FILL_FULL)
                    begin
                        fin     = 1'b1;
                        fin_rsp = '{status: ST_FULL, entry_index: 12'd0};
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_valid)
                begin
                    state_next = S_HREAD;
                end
            end
            S_HREAD:
            begin
                hd_re      = 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                // Head data is back: push new entry, miss on an empty bucket, or start the walk
                priority if (is_insert)
                begin
                    hd_we     = 1'b1;
                    en_we     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                    fin       = 1'b1;
                    fin_rsp   = '{status: ST_DONE, entry_index: 12'(slot)};
                end
                else if (hd_rdata == '0)
                begin
                    fin     = 1'b1;
                    fin_rsp = '{status: ST_NOT_FOUND, entry_index: 12'd0};
                end
                else
                begin
                    en_re      = 1'b1;
                    en_raddr   = hd_rdata;
                    cur_next   = hd_rdata;
                    state_next = S_CHASE;
                end
            end
            S_CHASE:
            begin
                // Compare current entry; stop on a match or a zero link, else follow the link with a new read
                priority if (rd_id == req_reg.label_id)
                begin
                    fin     = 1'b1;
                    fin_rsp = '{status: ST_DONE, entry_index: 12'(cur_reg)};
                end
                else if (rd_link == '0)
                begin
                    fin     = 1'b1;
                    fin_rsp = '{status: ST_NOT_FOUND, entry_index: 12'd0};
                end
                else
                begin
                    en_re    = 1'b1;
                    en_raddr = rd_link;
                    cur_next = rd_link;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // Result register and holding register
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (fin)
        begin
            if (out_free)
            begin
                rsp_next       = fin_rsp;
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                res_next   = fin_rsp;
                state_next = S_RESP;
            end
        end
        else if (state_reg == S_RESP && out_free)
        begin
            rsp_next       = res_reg;
            rsp_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            fill_reg      <= FILL_W'(1);
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            abs_sec_reg   <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                abs_sec_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        cur_reg <= cur_next;
        rsp_reg <= rsp_next;
        res_reg <= res_next;
    end

endmodule

[sv/lht_checker.sv]
// Label hash table: port-level checker and its bind to the top level.
// Depends on lht_pkg and label_hash_table.
module lht_checker
    import lht_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp item changed while stalled");

    // Only a successful item carries an index
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_DONE |-> rsp.entry_index == 12'd0)
        else $error("nonzero index on a failed item");

    // An ignored item answers in the next cycle when rsp is free
    a_ignore_fast: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.label_id == 31'd0 || req.operation == OP_RESERVED)
        && (!rsp_valid || rsp_ready)
        |=> rsp_valid && rsp.status == ST_IGNORED && rsp.entry_index == 12'd0)
        else $error("ignored item not answered at once");

endmodule

bind label_hash_table lht_checker u_lht_checker (.*);

[sim/tb_label_hash_table.sv]
// Testbench for label_hash_table: directed table plus random inserts and lookups,
// checked item by item against a behavioral model of the chained hash table.
// Depends on lht_pkg and label_hash_table.
`timescale 1ns / 100ps

module tb_label_hash_table;
    import lht_pkg::*;

    localparam int ENTRIES          = 4096;
    localparam int BUCKETS          = 1024;
    localparam int HALF_PERIOD      = 5;
    localparam int RANDOM_PER_PHASE = 460;
    localparam int HOLD_CYCLES      = 120;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int TAIL_CYCLES      = 16;

    // One row of the directed table; want is used only when fixed is set
    typedef struct {
        req_t item;
        bit   fixed;
        rsp_t want;
    } probe_row_t;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    // Model of the table contents
    int unsigned heads_m [BUCKETS];
    int unsigned links_m [ENTRIES];
    logic [30:0] ids_m [ENTRIES];
    logic [31:0] offsets_m [ENTRIES];
    logic [7:0]  sections_m [ENTRIES];
    int unsigned next_slot;
    logic [7:0]  abs_code_m;
    logic [30:0] known_ids [$];

    rsp_t        answers_due [$];
    probe_row_t  probes [$];
    int          error_count;
    int          quiet_cycles;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    bit          hold_pending;

    label_hash_table #(
        .ENTRIES (ENTRIES),
        .BUCKETS (BUCKETS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock
    always #HALF_PERIOD clk = ~clk;

    // Double multiply-add hash, 32-bit wrap, bits 16 and up masked to the bucket range
    function automatic int unsigned bucket_for(input logic [30:0] id);
        logic [31:0] h;
        h = {1'b0, id} * HASH_MUL + HASH_ADD;
        h = h * HASH_MUL + HASH_ADD;
        return (h >> HASH_SHIFT) & (BUCKETS - 1);
    endfunction

    // Apply one item to the model and return the answer it should give
    function automatic rsp_t table_answer(input req_t r);
        rsp_t        a;
        int unsigned b;
        int unsigned slot;
        int unsigned walk;
        int unsigned steps;
        bit          found;
        a.status      = ST_IGNORED;
        a.entry_index = '0;
        if (r.label_id != 0 && (r.operation == OP_INSERT || r.operation == OP_INSERT_ABS))
        begin
            if (next_slot >= ENTRIES)
            begin
                a.status = ST_FULL;
            end
            else
            begin
                b                = bucket_for(r.label_id);
                slot             = next_slot;
                ids_m[slot]      = r.label_id;
                offsets_m[slot]  = r.offset;
                sections_m[slot] = (r.operation == OP_INSERT) ? r.section : abs_code_m;
                links_m[slot]    = heads_m[b];
                heads_m[b]       = slot;
                next_slot        = slot + 1;
                known_ids.push_back(r.label_id);
                a.status         = ST_DONE;
                a.entry_index    = slot[11:0];
            end
        end
        else if (r.label_id != 0 && r.operation == OP_LOOKUP)
        begin
            // newest entry first; first id match wins
            a.status = ST_NOT_FOUND;
            walk     = heads_m[bucket_for(r.label_id)];
            steps    = 0;
            found    = 1'b0;
            while (walk != 0 && !found && steps < ENTRIES)
            begin
                if (ids_m[walk] == r.label_id)
                begin
                    found         = 1'b1;
                    a.status      = ST_DONE;
                    a.entry_index = walk[11:0];
                end
                else
                begin
                    walk  = links_m[walk];
                    steps = steps + 1;
                end
            end
        end
        return a;
    endfunction

    // Another nonzero id that hashes to the same bucket as ref_id
    function automatic logic [30:0] bucket_partner(input logic [30:0] ref_id,
                                                   input logic [30:0] skip_id);
        logic [30:0] cand;
        cand = 31'd2;
        while (bucket_for(cand) != bucket_for(ref_id) || cand == ref_id || cand == skip_id)
            cand = cand + 31'd1;
        return cand;
    endfunction

    function automatic probe_row_t probe(input logic [1:0] op, input logic [30:0] id,
                                         input logic [31:0] ofs, input logic [7:0] sec,
                                         input bit fixed, input logic [1:0] st,
                                         input logic [11:0] idx);
        probe_row_t p;
        p.item.operation   = op;
        p.item.label_id    = id;
        p.item.offset      = ofs;
        p.item.section     = sec;
        p.fixed            = fixed;
        p.want.status      = st;
        p.want.entry_index = idx;
        return p;
    endfunction

    // Random item: mostly inserts and lookups of ids already in the table
    function automatic req_t random_item(input int unsigned insert_pct);
        req_t        r;
        int unsigned pick;
        pick      = $urandom_range(99);
        r.offset  = $urandom;
        r.section = 8'($urandom_range(255));
        if (pick < insert_pct * 3 / 4)
            r.operation = OP_INSERT;
        else if (pick < insert_pct)
            r.operation = OP_INSERT_ABS;
        else if (pick < 93)
            r.operation = OP_LOOKUP;
        else
            r.operation = OP_RESERVED;
        pick = $urandom_range(99);
        if (pick < 4)
            r.label_id = '0;
        else if (known_ids.size() != 0 && pick < ((r.operation == OP_LOOKUP) ? 75 : 22))
            r.label_id = known_ids[$urandom_range(known_ids.size() - 1)];
        else if (pick < 30)
            r.label_id = 31'($urandom_range(15, 1));
        else
        begin
            r.label_id = 31'($urandom);
            if (r.label_id == 0)
                r.label_id = 31'h7FFF_FFFF;
        end
        return r;
    endfunction

    // Offer one item, hold it until taken, then record the expected answer
    task automatic send_item(input req_t r, input bit fixed, input rsp_t want);
        rsp_t a;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        a = table_answer(r);
        answers_due.push_back(fixed ? want : a);
    endtask

    // Stop offering and wait until every answer is back
    task automatic drain_answers();
        @(negedge clk);
        req_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_abs_code(input logic [7:0] code);
        @(negedge clk);
        cfg_data  <= code;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        abs_code_m = code;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off when requested
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending && rst_n)
            begin
                hold_pending = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Answer checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected item: status %0d entry_index %0d",
                       rsp.status, rsp.entry_index);
                error_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    error_count++;
                end
                if (rsp.entry_index !== want.entry_index)
                begin
                    $error("entry_index: expected %0d, got %0d",
                           want.entry_index, rsp.entry_index);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on any channel
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no item moved for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        logic [30:0] partner_a;
        logic [30:0] partner_b;
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        error_count  = 0;
        quiet_cycles = 0;
        hold_pending = 1'b0;
        snd_idle_pct = 14;
        rcv_idle_pct = 65;
        for (int i = 0; i < BUCKETS; i++)
            heads_m[i] = 0;
        next_slot  = 1;
        abs_code_m = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // taken while the bucket heads are being cleared
        write_abs_code(8'hFF);

        // Directed table: empty table, zero ids, reserved op, extremes, collisions
        partner_a = bucket_partner(31'd1, 31'd1);
        partner_b = bucket_partner(31'd1, partner_a);
        probes.push_back(probe(OP_LOOKUP, 31'd5, 32'd0, 8'd0, 1'b1, ST_NOT_FOUND, 12'd0));
        probes.push_back(probe(OP_INSERT, 31'd0, 32'd7, 8'd3, 1'b1, ST_IGNORED, 12'd0));
        probes.push_back(probe(OP_LOOKUP, 31'd0, 32'd0, 8'd0, 1'b1, ST_IGNORED, 12'd0));
        probes.push_back(probe(OP_RESERVED, 31'd7, 32'd0, 8'd0, 1'b1, ST_IGNORED, 12'd0));
        probes.push_back(probe(OP_INSERT, 31'd1, 32'd0, 8'd0, 1'b1, ST_DONE, 12'd1));
        probes.push_back(probe(OP_INSERT_ABS, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                               1'b1, ST_DONE, 12'd2));
        probes.push_back(probe(OP_LOOKUP, 31'd1, 32'd0, 8'd0, 1'b1, ST_DONE, 12'd1));
        probes.push_back(probe(OP_LOOKUP, 31'h7FFF_FFFF, 32'd0, 8'd0, 1'b1, ST_DONE,
                               12'd2));
        probes.push_back(probe(OP_INSERT, 31'd1, 32'h1234_5678, 8'h42, 1'b1, ST_DONE,
                               12'd3));
        probes.push_back(probe(OP_LOOKUP, 31'd1, 32'd0, 8'd0, 1'b1, ST_DONE, 12'd3));
        probes.push_back(probe(OP_RESERVED, 31'd0, 32'hFFFF_FFFF, 8'hFF, 1'b1, ST_IGNORED,
                               12'd0));
        probes.push_back(probe(OP_INSERT_ABS, 31'd0, 32'd1, 8'd1, 1'b1, ST_IGNORED, 12'd0));
        probes.push_back(probe(OP_INSERT, partner_a, 32'h0000_0100, 8'h10, 1'b0, ST_DONE,
                               12'd0));
        probes.push_back(probe(OP_LOOKUP, 31'd1, 32'd0, 8'd0, 1'b0, ST_DONE, 12'd0));
        probes.push_back(probe(OP_LOOKUP, partner_b, 32'd0, 8'd0, 1'b0, ST_DONE, 12'd0));
        probes.push_back(probe(OP_LOOKUP, partner_a, 32'd0, 8'd0, 1'b0, ST_DONE, 12'd0));
        probes.push_back(probe(OP_INSERT, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 8'hAA, 1'b0,
                               ST_DONE, 12'd0));
        probes.push_back(probe(OP_INSERT_ABS, 31'h5555_5555, 32'h5555_5555, 8'h55, 1'b0,
                               ST_DONE, 12'd0));
        probes.push_back(probe(OP_LOOKUP, 31'h2AAA_AAAA, 32'd0, 8'd0, 1'b0, ST_DONE,
                               12'd0));
        probes.push_back(probe(OP_LOOKUP, 31'h5555_5555, 32'd0, 8'd0, 1'b0, ST_DONE,
                               12'd0));
        probes.push_back(probe(OP_RESERVED, 31'h7FFF_FFFF, 32'd0, 8'd0, 1'b1, ST_IGNORED,
                               12'd0));
        probes.push_back(probe(OP_LOOKUP, 31'h7FFF_FFFE, 32'd0, 8'd0, 1'b0, ST_DONE,
                               12'd0));
        foreach (probes[i])
            send_item(probes[i].item, probes[i].fixed, probes[i].want);
        drain_answers();
        write_abs_code(8'h00);

        // Random phases: slow receiver, then slow sender, then full speed
        for (int phase = 0; phase < 3; phase++)
        begin
            snd_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 65 : 0;
            rcv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 14 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (n == 100 && phase != 1)
                    hold_pending = 1'b1;
                send_item(random_item(55), 1'b0, '0);
            end
            drain_answers();
            write_abs_code((phase == 0) ? 8'($urandom_range(254, 1)) :
                           (phase == 1) ? 8'h80 : 8'hFF);
        end

        // Closing burst of mixed items under the last abs code
        for (int n = 0; n < 40; n++)
            send_item(random_item(50), 1'b0, '0);
        drain_answers();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
